@@ rtl/ipid_pkg.sv @@
package ipid_pkg;

    localparam int ENC_W    = 32;
    localparam int TGT_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int MAX_W    = 15;
    localparam int DRIVE_W  = 16;
    localparam int ERR_W    = 32;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CFG_PROP_GAIN  = 2'd0,
        CFG_INTEG_GAIN = 2'd1,
        CFG_DERIV_GAIN = 2'd2,
        CFG_MAX_DRIVE  = 2'd3
    } t_cfg_index;

    localparam logic ACT_STEP  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST  = 16'sd768;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST = 16'sd0;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST = 16'sd128;
    localparam logic [MAX_W-1:0]         MAX_DRIVE_RST  = 15'd255;

endpackage

@@ rtl/ipid_in_if.sv @@
interface ipid_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  action;
    logic signed [ipid_pkg::ENC_W-1:0]     encoder_count;
    logic signed [ipid_pkg::TGT_W-1:0]     target_ticks;

    modport source (output valid, output action, output encoder_count,
                    output target_ticks, input ready);
    modport sink   (input valid, input action, input encoder_count,
                    input target_ticks, output ready);
endinterface

@@ rtl/ipid_out_if.sv @@
interface ipid_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ipid_pkg::DRIVE_W-1:0]   drive;
    logic                                  clamped;

    modport source (output valid, output drive, output clamped, input ready);
    modport sink   (input valid, input drive, input clamped, output ready);
endinterface

@@ rtl/ipid_cfg_if.sv @@
interface ipid_cfg_if;
    logic                                  valid;
    logic                                  ready;
    ipid_pkg::t_cfg_index                  index;
    logic [ipid_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/incremental_pid_speed_loop.sv @@
// Incremental PID wheel speed loop, one control frame per transfer.
// i_in carries an action (step or clear), the absolute encoder count and the
// wanted ticks per frame; o_out returns the clamped drive value and a flag
// that is set when the drive sits at the plus or minus limit. i_cfg writes
// the gains and the drive limit, one register per transfer, and is always
// ready; it is meant to be used only while no frame is in flight.
// An accepted frame is held in the input register, and its result is
// registered into the output register and valid on o_out once that register
// is empty or its result is being taken by the receiver.
// One frame is taken every cycle while the output is not stalled. The cycle time is set by the single stage
// between the two registers: three signed multipliers, their sum, the
// truncating shift, the drive add and the limit compare.
// Reset loads the register reset values, zeroes the controller state and
// empties both registers. When the receiver stalls, the output register holds
// its result, the input register takes one more frame, and then i_in.ready
// falls until the output transfer completes.
module incremental_pid_speed_loop (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ipid_in_if.sink     i_in,
    ipid_out_if.source  o_out,
    ipid_cfg_if.sink    i_cfg
);

    // configuration registers
    logic signed [ipid_pkg::GAIN_W-1:0]  r_prop_gain;
    logic signed [ipid_pkg::GAIN_W-1:0]  r_integ_gain;
    logic signed [ipid_pkg::GAIN_W-1:0]  r_deriv_gain;
    logic        [ipid_pkg::MAX_W-1:0]   r_max_drive;

    // controller state
    logic        [ipid_pkg::ENC_W-1:0]   r_prev_encoder;
    logic signed [ipid_pkg::ERR_W-1:0]   r_prev_error;
    logic signed [ipid_pkg::ERR_W-1:0]   r_error_sum;
    logic signed [ipid_pkg::DRIVE_W-1:0] r_last_drive;

    // input register
    logic                                r_in_valid;
    logic                                r_in_action;
    logic        [ipid_pkg::ENC_W-1:0]   r_in_encoder;
    logic        [ipid_pkg::TGT_W-1:0]   r_in_target;

    // output register
    logic                                r_out_valid;
    logic signed [ipid_pkg::DRIVE_W-1:0] r_out_drive;
    logic                                r_out_clamped;

    logic                                w_adv;
    logic        [31:0]                  w_delta;
    logic        [31:0]                  w_target_ext;
    logic signed [31:0]                  w_err;
    logic signed [32:0]                  w_diff;
    logic signed [47:0]                  w_prod_p;
    logic signed [48:0]                  w_prod_d;
    logic signed [47:0]                  w_prod_i;
    logic signed [50:0]                  w_sum;
    logic signed [50:0]                  w_biased;
    logic signed [42:0]                  w_acc;
    logic signed [43:0]                  w_drv;
    logic signed [43:0]                  w_max;
    logic signed [43:0]                  w_neg_max;
    logic                                w_hit_hi;
    logic                                w_hit_lo;
    logic signed [32:0]                  w_sum_next;
    logic signed [31:0]                  w_sum_sat;

    logic signed [ipid_pkg::DRIVE_W-1:0] n_drive;
    logic                                n_clamped;
    logic signed [ipid_pkg::ERR_W-1:0]   n_prev_error;
    logic signed [ipid_pkg::ERR_W-1:0]   n_error_sum;
    logic        [ipid_pkg::ENC_W-1:0]   n_prev_encoder;

    assign w_adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid   = r_out_valid;
    assign o_out.drive   = r_out_drive;
    assign o_out.clamped = r_out_clamped;

    // error with 32-bit wrap, derivative difference formed exactly at 33 bits
    assign w_delta      = r_in_encoder - r_prev_encoder;
    assign w_target_ext = {{(32-ipid_pkg::TGT_W){r_in_target[ipid_pkg::TGT_W-1]}}, r_in_target};
    assign w_err        = $signed(w_target_ext - w_delta);
    assign w_diff       = 33'(w_err) - 33'(r_prev_error);

    assign w_prod_p = 48'(r_prop_gain) * 48'(w_err);
    assign w_prod_d = 49'(r_deriv_gain) * 49'(w_diff);
    assign w_prod_i = 48'(r_integ_gain) * 48'(r_error_sum);
    assign w_sum    = 51'(w_prod_p) + 51'(w_prod_d) + 51'(w_prod_i);

    // Division by 256 rounds toward zero, so negative sums are biased first.
    assign w_biased = w_sum + (w_sum[50] ? 51'sd255 : 51'sd0);
    assign w_acc    = $signed(w_biased[50:8]);
    assign w_drv    = 44'(w_acc) + 44'(r_last_drive);

    assign w_max     = $signed({29'd0, r_max_drive});
    assign w_neg_max = -w_max;
    assign w_hit_hi  = (w_drv >= w_max);
    assign w_hit_lo  = (w_drv <= w_neg_max);

    assign w_sum_next = 33'(r_error_sum) + 33'(w_err);
    assign w_sum_sat  = (w_sum_next[32] != w_sum_next[31])
                      ? (w_sum_next[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                      : w_sum_next[31:0];

    always_comb begin
        n_prev_encoder = r_prev_encoder;
        n_prev_error   = w_err;
        n_error_sum    = r_error_sum;
        n_clamped      = 1'b1;
        n_drive        = w_drv[15:0];
        if (r_in_action == ipid_pkg::ACT_CLEAR) begin
            n_prev_error = '0;
            n_error_sum  = '0;
            n_drive      = '0;
            n_clamped    = 1'b0;
        end else begin
            n_prev_encoder = r_in_encoder;
            if (w_hit_hi) begin
                n_drive = w_max[15:0];
            end else if (w_hit_lo) begin
                n_drive = w_neg_max[15:0];
            end else begin
                n_error_sum = w_sum_sat;
                n_clamped   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= ipid_pkg::PROP_GAIN_RST;
            r_integ_gain <= ipid_pkg::INTEG_GAIN_RST;
            r_deriv_gain <= ipid_pkg::DERIV_GAIN_RST;
            r_max_drive  <= ipid_pkg::MAX_DRIVE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ipid_pkg::CFG_PROP_GAIN:  r_prop_gain  <= $signed(i_cfg.data);
                ipid_pkg::CFG_INTEG_GAIN: r_integ_gain <= $signed(i_cfg.data);
                ipid_pkg::CFG_DERIV_GAIN: r_deriv_gain <= $signed(i_cfg.data);
                ipid_pkg::CFG_MAX_DRIVE:  r_max_drive  <= i_cfg.data[ipid_pkg::MAX_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_encoder <= '0;
            r_prev_error   <= '0;
            r_error_sum    <= '0;
            r_last_drive   <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_prev_encoder <= n_prev_encoder;
                r_prev_error   <= n_prev_error;
                r_error_sum    <= n_error_sum;
                r_last_drive   <= n_drive;
                r_out_valid    <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_action  <= i_in.action;
            r_in_encoder <= i_in.encoder_count;
            r_in_target  <= i_in.target_ticks;
        end
        if (w_adv) begin
            r_out_drive   <= n_drive;
            r_out_clamped <= n_clamped;
        end
    end

`ifndef SYNTHESIS
    a_clamp_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_clamped |->
            (r_out_drive == w_max[15:0]) || (r_out_drive == w_neg_max[15:0]))
        else $error("clamped result is not at the drive limit");

    a_free_inside_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_clamped |->
            (r_out_drive == '0) ||
            ((44'(r_out_drive) < w_max) && (44'(r_out_drive) > w_neg_max)))
        else $error("unclamped result lies outside the drive limit");

    a_last_drive_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> (r_last_drive == r_out_drive))
        else $error("stored drive differs from the delivered result");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_in_valid && r_out_valid && !o_out.ready))
        else $error("input held off without a stalled output");

    a_clear_keeps_encoder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && (r_in_action == ipid_pkg::ACT_CLEAR) |=>
            $stable(r_prev_encoder) && (r_error_sum == '0))
        else $error("clear transfer disturbed the encoder or left the sum");
`endif

endmodule

@@ tb/sv/incremental_pid_speed_loop_test.sv @@
module incremental_pid_speed_loop_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 80;

    typedef struct {
        logic                                action;
        logic [ipid_pkg::ENC_W-1:0]          count;
        logic signed [ipid_pkg::TGT_W-1:0]   ticks;
    } t_pid_frame;

    typedef struct {
        logic signed [ipid_pkg::DRIVE_W-1:0] drive;
        logic                                clamped;
    } t_drive_word;

    logic i_clk;
    logic i_rst_n;

    ipid_in_if  in_ch();
    ipid_out_if out_ch();
    ipid_cfg_if cfg_ch();

    incremental_pid_speed_loop u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predicted controller: gains, limit and loop state.
    logic signed [ipid_pkg::GAIN_W-1:0] gain_p;
    logic signed [ipid_pkg::GAIN_W-1:0] gain_i;
    logic signed [ipid_pkg::GAIN_W-1:0] gain_d;
    logic [ipid_pkg::MAX_W-1:0]         drive_limit;
    logic [ipid_pkg::ENC_W-1:0]         last_count;
    longint                             prev_err;
    longint                             err_sum;
    longint                             drive_now;

    t_drive_word expected_drives[$];

    logic [ipid_pkg::ENC_W-1:0] wheel_pos;
    int frames_sent;
    int clears_sent;
    int config_writes;
    int results_seen;
    int limit_hits;
    int drive_errors;
    int cycle_count;
    int rx_stall_pct;
    int hold_requests;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_drives.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_drive_word pid_predict(input t_pid_frame f);
        t_drive_word                r;
        logic [ipid_pkg::ERR_W-1:0] e_bits;
        longint                     err;
        longint                     acc;
        longint                     drv;
        longint                     lim;
        longint                     sum;
        if (f.action == ipid_pkg::ACT_CLEAR) begin
            err_sum   = 0;
            prev_err  = 0;
            drive_now = 0;
            r.drive   = '0;
            r.clamped = 1'b0;
            return r;
        end
        e_bits = {{(ipid_pkg::ERR_W-ipid_pkg::TGT_W){f.ticks[ipid_pkg::TGT_W-1]}}, f.ticks}
               - (f.count - last_count);
        err = longint'($signed(e_bits));
        // The derivative difference is kept at full width, it must not wrap.
        acc = longint'(gain_p) * err + longint'(gain_d) * (err - prev_err)
            + longint'(gain_i) * err_sum;
        acc = acc / 256;
        drv = acc + drive_now;
        lim = longint'(drive_limit);
        prev_err   = err;
        last_count = f.count;
        r.clamped  = 1'b1;
        if (drv >= lim) begin
            drv = lim;
        end else if (drv <= -lim) begin
            drv = -lim;
        end else begin
            sum = err_sum + err;
            if (sum > longint'(32'sh7FFF_FFFF)) sum = longint'(32'sh7FFF_FFFF);
            if (sum < longint'(32'sh8000_0000)) sum = longint'(32'sh8000_0000);
            err_sum   = sum;
            r.clamped = 1'b0;
        end
        drive_now = drv;
        r.drive   = drv[ipid_pkg::DRIVE_W-1:0];
        return r;
    endfunction

    function automatic t_pid_frame random_frame();
        t_pid_frame f;
        int         pick;
        int         speed;
        int         move;
        pick  = $urandom_range(0, 99);
        speed = $urandom_range(0, 600) - 300;
        move  = speed + int'($urandom_range(0, 40)) - 20;
        // Mostly a wheel that roughly follows its target, with some noise.
        f.action = ipid_pkg::ACT_STEP;
        f.ticks  = speed[ipid_pkg::TGT_W-1:0];
        f.count  = wheel_pos + move;
        if (pick < 6) begin
            f.action = ipid_pkg::ACT_CLEAR;
            f.count  = $urandom;
            f.ticks  = 16'($urandom);
        end else if (pick < 14) begin
            f.count = $urandom;
            f.ticks = 16'($urandom);
        end
        return f;
    endfunction

    // Holds valid high after the transfer so that back-to-back frames need no drop.
    task automatic send_frame(input logic act, input logic [ipid_pkg::ENC_W-1:0] cnt,
                              input logic signed [ipid_pkg::TGT_W-1:0] tks);
        t_pid_frame f;
        f.action = act;
        f.count  = cnt;
        f.ticks  = tks;
        in_ch.valid         <= 1'b1;
        in_ch.action        <= act;
        in_ch.encoder_count <= cnt;
        in_ch.target_ticks  <= tks;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        expected_drives.push_back(pid_predict(f));
        frames_sent++;
        if (act == ipid_pkg::ACT_CLEAR)
            clears_sent++;
        else
            wheel_pos = cnt;
    endtask

    task automatic write_reg(input ipid_pkg::t_cfg_index idx,
                             input logic [ipid_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        config_writes++;
        case (idx)
            ipid_pkg::CFG_PROP_GAIN:  gain_p = data;
            ipid_pkg::CFG_INTEG_GAIN: gain_i = data;
            ipid_pkg::CFG_DERIV_GAIN: gain_d = data;
            ipid_pkg::CFG_MAX_DRIVE:  drive_limit = data[ipid_pkg::MAX_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_gains(input logic [ipid_pkg::GAIN_W-1:0] kp,
                             input logic [ipid_pkg::GAIN_W-1:0] ki,
                             input logic [ipid_pkg::GAIN_W-1:0] kd,
                             input logic [ipid_pkg::MAX_W-1:0] lim);
        write_reg(ipid_pkg::CFG_PROP_GAIN, kp);
        write_reg(ipid_pkg::CFG_INTEG_GAIN, ki);
        write_reg(ipid_pkg::CFG_DERIV_GAIN, kd);
        write_reg(ipid_pkg::CFG_MAX_DRIVE, {1'b0, lim});
        cfg_ch.valid <= 1'b0;
    endtask

    // Drops valid and waits until every predicted result has been seen.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_drives.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_frames(input int total, input int max_gap);
        t_pid_frame f;
        int         left;
        int         burst;
        int         gap;
        left = total;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                f = random_frame();
                send_frame(f.action, f.count, f.ticks);
                burst--;
                left--;
            end
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_reset_values();
        rx_stall_pct = 30;
        send_frame(ipid_pkg::ACT_STEP, 32'h0, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, 32'h0, 16'sd1);
        send_frame(ipid_pkg::ACT_STEP, 32'd10, 16'sd5);
        send_frame(ipid_pkg::ACT_STEP, 32'd10, 16'sh7FFF);
        send_frame(ipid_pkg::ACT_STEP, 32'd10, 16'sh8000);
        send_frame(ipid_pkg::ACT_CLEAR, 32'h7FFF_FFFF, 16'sh7FFF);
        send_frame(ipid_pkg::ACT_STEP, 32'h7FFF_FFFF, 16'sd0);
        // The count wraps from the largest positive to the most negative value.
        send_frame(ipid_pkg::ACT_STEP, 32'h8000_0000, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, 32'hFFFF_FFFF, -16'sd1);
        // A clear keeps the previous count, so the next step sees no movement.
        send_frame(ipid_pkg::ACT_CLEAR, 32'h1234_5678, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, 32'hFFFF_FFFF, 16'sd0);
    endtask

    task automatic test_limit_equality();
        wait_idle();
        set_gains(16'sd256, 16'sd0, 16'sd0, 15'd100);
        send_frame(ipid_pkg::ACT_CLEAR, 32'h0, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos, 16'sd100);
        send_frame(ipid_pkg::ACT_CLEAR, 32'h0, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos, -16'sd100);
        send_frame(ipid_pkg::ACT_CLEAR, 32'h0, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos, 16'sd99);
        wait_idle();
        // A small negative product must truncate towards zero, not round down.
        set_gains(16'sd255, 16'sd0, 16'sd0, 15'd32767);
        send_frame(ipid_pkg::ACT_CLEAR, 32'h0, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos, -16'sd1);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos, 16'sd1);
    endtask

    task automatic test_derivative_span();
        wait_idle();
        set_gains(16'sd0, 16'sd0, 16'sd1, 15'd32767);
        send_frame(ipid_pkg::ACT_CLEAR, 32'h0, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos + 32'h8000_0001, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos + 32'h8000_0000, 16'sd0);
    endtask

    task automatic test_integral_saturation();
        wait_idle();
        set_gains(16'sd0, 16'sd0, 16'sd0, 15'd32767);
        send_frame(ipid_pkg::ACT_CLEAR, 32'h0, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos + 32'h8000_0001, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos + 32'h8000_0001, 16'sd0);
        wait_idle();
        set_gains(16'sd0, 16'sd1, 16'sd0, 15'd32767);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos, 16'sd0);
        wait_idle();
        set_gains(16'sd0, 16'sd0, 16'sd0, 15'd32767);
        send_frame(ipid_pkg::ACT_CLEAR, 32'h0, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos + 32'h8000_0000, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos + 32'h8000_0000, 16'sd0);
        wait_idle();
        set_gains(16'sd0, 16'sd1, 16'sd0, 15'd32767);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos, 16'sd0);
    endtask

    task automatic test_zero_limit();
        wait_idle();
        set_gains(16'sd768, 16'sd0, 16'sd128, 15'd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos + 32'd3, 16'sd10);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos, -16'sd7);
        send_frame(ipid_pkg::ACT_CLEAR, 32'h0, 16'sd0);
        send_frame(ipid_pkg::ACT_STEP, wheel_pos, 16'sd0);
    endtask

    task automatic test_random_settings();
        wait_idle();
        set_gains(16'sd768, 16'sd64, 16'sd128, 15'd255);
        rx_stall_pct = 0;
        run_frames(60, 0);
        rx_stall_pct = 30;
        run_frames(40, 5);
        wait_idle();
        set_gains(16'($urandom), 16'($urandom), 16'($urandom),
                  15'($urandom_range(1, 32767)));
        rx_stall_pct = 40;
        run_frames(70, 4);
        wait_idle();
        set_gains(16'sh8000, 16'sh7FFF, 16'sh8000, 15'd32767);
        rx_stall_pct = 25;
        run_frames(60, 3);
        wait_idle();
        set_gains(16'sh7FFF, 16'sh8000, 16'sh7FFF, 15'd1);
        rx_stall_pct = 60;
        run_frames(60, 8);
        wait_idle();
        set_gains(16'($urandom_range(0, 1024) - 512), 16'($urandom_range(0, 64) - 32),
                  16'($urandom_range(0, 512) - 256), 15'd32767);
        rx_stall_pct = 20;
        run_frames(60, 2);
    endtask

    // The receiver holds off for a long stretch while frames keep coming,
    // so both registers fill and the input stalls.
    task automatic test_backpressure();
        wait_idle();
        set_gains(16'sd768, 16'sd32, 16'sd128, 15'd2000);
        rx_stall_pct = 10;
        hold_requests++;
        run_frames(24, 0);
    endtask

    // Receiver: runs of ready and stall of random length, plus a long hold on request.
    initial begin
        int   hold_served;
        int   hold_left;
        int   run_left;
        logic ready_state;
        hold_served = 0;
        hold_left   = 0;
        run_left    = 0;
        ready_state = 1'b1;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    ready_state = ($urandom_range(0, 99) < rx_stall_pct) ? 1'b0 : 1'b1;
                    run_left    = $urandom_range(1, 6);
                end
                run_left--;
                out_ch.ready <= ready_state;
            end
        end
    end

    // Result checker: every output transfer is matched against the oldest prediction.
    initial begin
        t_drive_word want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                results_seen++;
                if (out_ch.clamped === 1'b1) limit_hits++;
                if (expected_drives.size() == 0) begin
                    drive_errors++;
                    if (drive_errors <= 10)
                        $display("unexpected result at cycle %0d: drive %0d clamped %0b",
                                 cycle_count, out_ch.drive, out_ch.clamped);
                end else begin
                    want = expected_drives.pop_front();
                    if (out_ch.drive !== want.drive || out_ch.clamped !== want.clamped) begin
                        drive_errors++;
                        if (drive_errors <= 10)
                            $display("drive mismatch at cycle %0d: expected %0d/%0b, got %0d/%0b",
                                     cycle_count, want.drive, want.clamped,
                                     out_ch.drive, out_ch.clamped);
                    end
                end
            end
        end
    end

    initial begin
        cycle_count   = 0;
        frames_sent   = 0;
        clears_sent   = 0;
        config_writes = 0;
        results_seen  = 0;
        limit_hits    = 0;
        drive_errors  = 0;
        rx_stall_pct  = 0;
        hold_requests = 0;
        wheel_pos     = '0;
        gain_p        = ipid_pkg::PROP_GAIN_RST;
        gain_i        = ipid_pkg::INTEG_GAIN_RST;
        gain_d        = ipid_pkg::DERIV_GAIN_RST;
        drive_limit   = ipid_pkg::MAX_DRIVE_RST;
        last_count    = '0;
        prev_err      = 0;
        err_sum       = 0;
        drive_now     = 0;
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.action        <= ipid_pkg::ACT_STEP;
        in_ch.encoder_count <= '0;
        in_ch.target_ticks  <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= ipid_pkg::CFG_PROP_GAIN;
        cfg_ch.data         <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_limit_equality();
        test_derivative_span();
        test_integral_saturation();
        test_zero_limit();
        test_random_settings();
        test_backpressure();
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("Ran %0d control frames (%0d clears) through %0d register writes,",
                 frames_sent, clears_sent, config_writes);
        $display("checked %0d drive values, %0d of them at the limit, %0d mismatches.",
                 results_seen, limit_hits, drive_errors);
        if (drive_errors == 0 && expected_drives.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ incremental_pid_speed_loop.f @@
rtl/ipid_pkg.sv
rtl/ipid_in_if.sv
rtl/ipid_out_if.sv
rtl/ipid_cfg_if.sv
rtl/incremental_pid_speed_loop.sv
tb/sv/incremental_pid_speed_loop_test.sv
